[hw/rtl/lgtr_pkg.sv]
package lgtr_pkg;

	localparam int TW          = 6;
	localparam int TOPIC_DEPTH = 64;
	localparam int CNT_W       = 24;
	localparam int PRI_W       = 24;
	localparam int OPND_W      = 41;
	localparam int PROD_W      = 82;
	localparam int NUM_W       = 98;
	localparam int DEN_W       = 41;
	localparam int WGT_W       = 64;
	localparam int TOT_W       = 70;
	localparam int VB_W        = 37;
	localparam int FRAC_W      = 32;

	localparam logic [1:0] CFG_TOPIC_COUNT = 2'd0;
	localparam logic [1:0] CFG_VOCAB_SIZE  = 2'd1;
	localparam logic [1:0] CFG_ALPHA       = 2'd2;
	localparam logic [1:0] CFG_BETA        = 2'd3;

	localparam logic [6:0]       RST_TOPIC_COUNT = 7'd64;
	localparam logic [12:0]      RST_VOCAB_SIZE  = 13'd4096;
	localparam logic [PRI_W-1:0] RST_ALPHA       = 24'd6554;
	localparam logic [PRI_W-1:0] RST_BETA        = 24'd655;

	typedef enum logic [4:0] {
		OP_CLEAR,
		OP_IDLE,
		OP_CHECK,
		OP_RD_OLD,
		OP_DEC,
		OP_W_RD,
		OP_W_LD,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_DIV_GO,
		OP_NONE,
		OP_W_ACC,
		OP_TH0,
		OP_TH1,
		OP_TH2,
		OP_TH3,
		OP_P_RD,
		OP_P_CHK,
		OP_INC_RD,
		OP_INC_WR,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_RD_OLD,
		ST_DEC,
		ST_W_RD,
		ST_W_LD,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_W_ACC,
		ST_TH0,
		ST_TH1,
		ST_TH2,
		ST_TH3,
		ST_P_RD,
		ST_P_CHK,
		ST_INC_RD,
		ST_INC_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic range_ok;
		logic func_add;
		logic k_last;
		logic hit;
		logic den_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/lgtr_ram.sv]
module lgtr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/lgtr_div.sv]
module lgtr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lgtr_pkg::NUM_W-1:0]  dividend,
	input  logic [lgtr_pkg::DEN_W-1:0]  divisor,
	output logic                        done,
	output logic                        busy,
	output logic [lgtr_pkg::WGT_W-1:0]  quot
);

	localparam int SW = $clog2(lgtr_pkg::NUM_W);

	logic                       busy_q;
	logic                       done_q;
	logic [SW-1:0]              cnt_q;
	logic [lgtr_pkg::NUM_W-1:0] n_q;
	logic [lgtr_pkg::DEN_W-1:0] d_q;
	logic [lgtr_pkg::DEN_W-1:0] r_q;
	logic [lgtr_pkg::WGT_W-1:0] q_q;
	logic                       sat_q;
	logic [lgtr_pkg::DEN_W:0]   rr;
	logic                       qbit;
	logic [lgtr_pkg::DEN_W:0]   rsub;

	assign rr   = {r_q, n_q[lgtr_pkg::NUM_W-1]};
	assign qbit = rr >= {1'b0, d_q};
	assign rsub = qbit ? rr - {1'b0, d_q} : rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == SW'(lgtr_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			r_q   <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			r_q   <= rsub[lgtr_pkg::DEN_W-1:0];
			q_q   <= {q_q[lgtr_pkg::WGT_W-2:0], qbit};
			sat_q <= sat_q | q_q[lgtr_pkg::WGT_W-1];
		end
	end

	assign done = done_q;
	assign busy = busy_q;
	assign quot = sat_q ? '1 : q_q;

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a run");
	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && $past(busy_q)) |-> (r_q < d_q))
		else $error("divider remainder not below divisor");
`endif

endmodule

[hw/rtl/lgtr_ctrl.sv]
module lgtr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lgtr_pkg::status_t status,
	output lgtr_pkg::cmd_t    cmd,
	output logic              in_ready
);

	lgtr_pkg::state_t state_q;
	lgtr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgtr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lgtr_pkg::ST_CLEAR: begin
				if (status.clear_last) state_d = lgtr_pkg::ST_IDLE;
			end
			lgtr_pkg::ST_IDLE: begin
				if (in_valid) state_d = lgtr_pkg::ST_CHECK;
			end
			lgtr_pkg::ST_CHECK: begin
				if (!status.range_ok) state_d = lgtr_pkg::ST_DONE;
				else if (status.func_add) state_d = lgtr_pkg::ST_INC_RD;
				else state_d = lgtr_pkg::ST_RD_OLD;
			end
			lgtr_pkg::ST_RD_OLD: state_d = lgtr_pkg::ST_DEC;
			lgtr_pkg::ST_DEC:    state_d = lgtr_pkg::ST_W_RD;
			lgtr_pkg::ST_W_RD:   state_d = lgtr_pkg::ST_W_LD;
			lgtr_pkg::ST_W_LD:   state_d = lgtr_pkg::ST_MUL0;
			lgtr_pkg::ST_MUL0:   state_d = lgtr_pkg::ST_MUL1;
			lgtr_pkg::ST_MUL1:   state_d = lgtr_pkg::ST_MUL2;
			lgtr_pkg::ST_MUL2:   state_d = lgtr_pkg::ST_DIV_GO;
			lgtr_pkg::ST_DIV_GO: begin
				state_d = status.den_zero ? lgtr_pkg::ST_W_ACC : lgtr_pkg::ST_DIV_WAIT;
			end
			lgtr_pkg::ST_DIV_WAIT: begin
				if (status.div_done) state_d = lgtr_pkg::ST_W_ACC;
			end
			lgtr_pkg::ST_W_ACC: begin
				state_d = status.k_last ? lgtr_pkg::ST_TH0 : lgtr_pkg::ST_W_RD;
			end
			lgtr_pkg::ST_TH0: state_d = lgtr_pkg::ST_TH1;
			lgtr_pkg::ST_TH1: state_d = lgtr_pkg::ST_TH2;
			lgtr_pkg::ST_TH2: state_d = lgtr_pkg::ST_TH3;
			lgtr_pkg::ST_TH3: state_d = lgtr_pkg::ST_P_RD;
			lgtr_pkg::ST_P_RD: state_d = lgtr_pkg::ST_P_CHK;
			lgtr_pkg::ST_P_CHK: begin
				if (status.hit || status.k_last) state_d = lgtr_pkg::ST_INC_RD;
				else state_d = lgtr_pkg::ST_P_RD;
			end
			lgtr_pkg::ST_INC_RD: state_d = lgtr_pkg::ST_INC_WR;
			lgtr_pkg::ST_INC_WR: state_d = lgtr_pkg::ST_DONE;
			lgtr_pkg::ST_DONE: begin
				if (status.out_free) state_d = lgtr_pkg::ST_IDLE;
			end
			default: state_d = lgtr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = lgtr_pkg::OP_NONE;
		case (state_q)
			lgtr_pkg::ST_CLEAR:    cmd.op = lgtr_pkg::OP_CLEAR;
			lgtr_pkg::ST_IDLE:     cmd.op = lgtr_pkg::OP_IDLE;
			lgtr_pkg::ST_CHECK:    cmd.op = lgtr_pkg::OP_CHECK;
			lgtr_pkg::ST_RD_OLD:   cmd.op = lgtr_pkg::OP_RD_OLD;
			lgtr_pkg::ST_DEC:      cmd.op = lgtr_pkg::OP_DEC;
			lgtr_pkg::ST_W_RD:     cmd.op = lgtr_pkg::OP_W_RD;
			lgtr_pkg::ST_W_LD:     cmd.op = lgtr_pkg::OP_W_LD;
			lgtr_pkg::ST_MUL0:     cmd.op = lgtr_pkg::OP_MUL0;
			lgtr_pkg::ST_MUL1:     cmd.op = lgtr_pkg::OP_MUL1;
			lgtr_pkg::ST_MUL2:     cmd.op = lgtr_pkg::OP_MUL2;
			lgtr_pkg::ST_DIV_GO:   cmd.op = lgtr_pkg::OP_DIV_GO;
			lgtr_pkg::ST_DIV_WAIT: cmd.op = lgtr_pkg::OP_NONE;
			lgtr_pkg::ST_W_ACC:    cmd.op = lgtr_pkg::OP_W_ACC;
			lgtr_pkg::ST_TH0:      cmd.op = lgtr_pkg::OP_TH0;
			lgtr_pkg::ST_TH1:      cmd.op = lgtr_pkg::OP_TH1;
			lgtr_pkg::ST_TH2:      cmd.op = lgtr_pkg::OP_TH2;
			lgtr_pkg::ST_TH3:      cmd.op = lgtr_pkg::OP_TH3;
			lgtr_pkg::ST_P_RD:     cmd.op = lgtr_pkg::OP_P_RD;
			lgtr_pkg::ST_P_CHK:    cmd.op = lgtr_pkg::OP_P_CHK;
			lgtr_pkg::ST_INC_RD:   cmd.op = lgtr_pkg::OP_INC_RD;
			lgtr_pkg::ST_INC_WR:   cmd.op = lgtr_pkg::OP_INC_WR;
			lgtr_pkg::ST_DONE: begin
				cmd.op = status.out_free ? lgtr_pkg::OP_OUT : lgtr_pkg::OP_NONE;
			end
			default: cmd.op = lgtr_pkg::OP_NONE;
		endcase
	end

	assign in_ready = state_q == lgtr_pkg::ST_IDLE;

endmodule

[hw/rtl/lgtr_dp.sv]
module lgtr_dp #(
	parameter int MAX_TOPICS = 64,
	parameter int MAX_WORDS  = 4096,
	parameter int MAX_DOCS   = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [lgtr_pkg::PRI_W-1:0]   cfg_data,
	input  logic                         in_valid,
	input  logic                         func,
	input  logic [9:0]                   doc_index,
	input  logic [11:0]                  word_id,
	input  logic [5:0]                   old_topic,
	input  logic [lgtr_pkg::FRAC_W-1:0]  random_fraction,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [5:0]                   new_topic,
	input  lgtr_pkg::cmd_t               cmd,
	output lgtr_pkg::status_t            status
);

	localparam int TOPICS_EFF = MAX_TOPICS < 64 ? MAX_TOPICS : 64;
	localparam int WORDS_EFF  = MAX_WORDS < 4096 ? MAX_WORDS : 4096;
	localparam int DOCS_EFF   = MAX_DOCS < 1024 ? MAX_DOCS : 1024;
	localparam int WDEPTH     = WORDS_EFF * lgtr_pkg::TOPIC_DEPTH;
	localparam int DDEPTH     = DOCS_EFF * lgtr_pkg::TOPIC_DEPTH;
	localparam int WAW        = $clog2(WDEPTH);
	localparam int DAW        = $clog2(DDEPTH);
	localparam int CLR_DEPTH  = WDEPTH > DDEPTH ? WDEPTH : DDEPTH;
	localparam int CLW        = $clog2(CLR_DEPTH);
	localparam int TW         = lgtr_pkg::TW;

	logic [6:0]                   topic_count_q;
	logic [12:0]                  vocab_size_q;
	logic [lgtr_pkg::PRI_W-1:0]   alpha_q;
	logic [lgtr_pkg::PRI_W-1:0]   beta_q;

	logic                         func_q;
	logic [9:0]                   doc_q;
	logic [11:0]                  word_q;
	logic [TW-1:0]                old_q;
	logic [lgtr_pkg::FRAC_W-1:0]  frac_q;
	logic [6:0]                   kn_q;
	logic [lgtr_pkg::VB_W-1:0]    vb_q;
	logic [TW-1:0]                k_q;
	logic [TW-1:0]                pick_q;
	logic [lgtr_pkg::OPND_W-1:0]  a_q;
	logic [lgtr_pkg::OPND_W-1:0]  b_q;
	logic [lgtr_pkg::DEN_W-1:0]   den_q;
	logic [61:0]                  pp_q;
	logic [lgtr_pkg::PROD_W-1:0]  prod_q;
	logic [lgtr_pkg::TOT_W-1:0]   total_q;
	logic [63:0]                  tp_q;
	logic [lgtr_pkg::TOT_W-1:0]   thr_q;
	logic [lgtr_pkg::TOT_W-1:0]   run_q;
	logic                         out_valid_q;
	logic [TW-1:0]                new_topic_q;
	logic [CLW-1:0]               clr_cnt_q;

	logic                         accept;
	logic                         is_clr;
	logic [6:0]                   kn_d;
	logic [TW-1:0]                kn_m1;
	logic [TW-1:0]                topic_sel;
	logic [WAW-1:0]               w_addr;
	logic [DAW-1:0]               d_addr;
	logic [TW-1:0]                t_addr;
	logic [lgtr_pkg::CNT_W-1:0]   tot_rd;
	logic [lgtr_pkg::CNT_W-1:0]   word_rd;
	logic [lgtr_pkg::CNT_W-1:0]   doc_rd;
	logic [lgtr_pkg::WGT_W-1:0]   wgt_rd;
	logic [lgtr_pkg::CNT_W-1:0]   tot_wd;
	logic [lgtr_pkg::CNT_W-1:0]   word_wd;
	logic [lgtr_pkg::CNT_W-1:0]   doc_wd;
	logic                         upd;
	logic                         tot_we;
	logic                         word_we;
	logic                         doc_we;
	logic                         den_zero;
	logic                         div_start;
	logic                         div_done;
	logic                         div_busy;
	logic [lgtr_pkg::WGT_W-1:0]   div_quot;
	logic [lgtr_pkg::WGT_W-1:0]   weight;
	logic [lgtr_pkg::TOT_W-1:0]   run_next;
	logic                         out_free;

	function automatic logic [lgtr_pkg::CNT_W-1:0] cnt_step(
		input logic [lgtr_pkg::CNT_W-1:0] c,
		input logic                       up
	);
		if (up) return (c == '1) ? c : c + lgtr_pkg::CNT_W'(1);
		return (c == '0) ? c : c - lgtr_pkg::CNT_W'(1);
	endfunction

	assign accept = (cmd.op == lgtr_pkg::OP_IDLE) && in_valid;
	assign is_clr = cmd.op == lgtr_pkg::OP_CLEAR;

	always_comb begin
		kn_d = (topic_count_q == 7'd0) ? 7'd1 : topic_count_q;
		if (32'(kn_d) > TOPICS_EFF) kn_d = 7'(TOPICS_EFF);
	end

	assign kn_m1 = TW'(kn_q - 7'd1);

	always_comb begin
		case (cmd.op)
			lgtr_pkg::OP_RD_OLD, lgtr_pkg::OP_DEC:    topic_sel = old_q;
			lgtr_pkg::OP_INC_RD, lgtr_pkg::OP_INC_WR: topic_sel = pick_q;
			default:                                  topic_sel = k_q;
		endcase
	end

	assign w_addr = is_clr ? clr_cnt_q[WAW-1:0]
		: WAW'((32'(word_q) << TW) | 32'(topic_sel));
	assign d_addr = is_clr ? clr_cnt_q[DAW-1:0]
		: DAW'((32'(doc_q) << TW) | 32'(topic_sel));
	assign t_addr = is_clr ? clr_cnt_q[TW-1:0] : topic_sel;

	assign upd     = (cmd.op == lgtr_pkg::OP_DEC) || (cmd.op == lgtr_pkg::OP_INC_WR);
	assign tot_we  = (is_clr && (32'(clr_cnt_q) < lgtr_pkg::TOPIC_DEPTH)) || upd;
	assign word_we = (is_clr && (32'(clr_cnt_q) < WDEPTH)) || upd;
	assign doc_we  = (is_clr && (32'(clr_cnt_q) < DDEPTH)) || upd;
	assign tot_wd  = is_clr ? '0 : cnt_step(tot_rd, cmd.op == lgtr_pkg::OP_INC_WR);
	assign word_wd = is_clr ? '0 : cnt_step(word_rd, cmd.op == lgtr_pkg::OP_INC_WR);
	assign doc_wd  = is_clr ? '0 : cnt_step(doc_rd, cmd.op == lgtr_pkg::OP_INC_WR);

	lgtr_ram #(.WIDTH(lgtr_pkg::CNT_W), .DEPTH(lgtr_pkg::TOPIC_DEPTH)) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (t_addr),
		.wdata (tot_wd),
		.raddr (t_addr),
		.rdata (tot_rd)
	);

	lgtr_ram #(.WIDTH(lgtr_pkg::CNT_W), .DEPTH(WDEPTH)) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (w_addr),
		.wdata (word_wd),
		.raddr (w_addr),
		.rdata (word_rd)
	);

	lgtr_ram #(.WIDTH(lgtr_pkg::CNT_W), .DEPTH(DDEPTH)) u_doc_ram (
		.clk   (clk),
		.we    (doc_we),
		.waddr (d_addr),
		.wdata (doc_wd),
		.raddr (d_addr),
		.rdata (doc_rd)
	);

	assign den_zero  = den_q == '0;
	assign div_start = (cmd.op == lgtr_pkg::OP_DIV_GO) && !den_zero;

	lgtr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({prod_q, 16'b0}),
		.divisor  (den_q),
		.done     (div_done),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	assign weight = den_zero ? ((prod_q == '0) ? '0 : '1) : div_quot;

	lgtr_ram #(.WIDTH(lgtr_pkg::WGT_W), .DEPTH(lgtr_pkg::TOPIC_DEPTH)) u_wgt_ram (
		.clk   (clk),
		.we    (cmd.op == lgtr_pkg::OP_W_ACC),
		.waddr (k_q),
		.wdata (weight),
		.raddr (k_q),
		.rdata (wgt_rd)
	);

	assign run_next = run_q + lgtr_pkg::TOT_W'(wgt_rd);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topic_count_q <= lgtr_pkg::RST_TOPIC_COUNT;
			vocab_size_q  <= lgtr_pkg::RST_VOCAB_SIZE;
			alpha_q       <= lgtr_pkg::RST_ALPHA;
			beta_q        <= lgtr_pkg::RST_BETA;
			out_valid_q   <= 1'b0;
			clr_cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lgtr_pkg::CFG_TOPIC_COUNT: topic_count_q <= cfg_data[6:0];
					lgtr_pkg::CFG_VOCAB_SIZE:  vocab_size_q  <= cfg_data[12:0];
					lgtr_pkg::CFG_ALPHA:       alpha_q       <= cfg_data;
					lgtr_pkg::CFG_BETA:        beta_q        <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == lgtr_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (is_clr) clr_cnt_q <= clr_cnt_q + CLW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			doc_q   <= doc_index;
			word_q  <= word_id;
			old_q   <= old_topic;
			frac_q  <= random_fraction;
			kn_q    <= kn_d;
			vb_q    <= lgtr_pkg::VB_W'(vocab_size_q) * lgtr_pkg::VB_W'(beta_q);
			k_q     <= '0;
			total_q <= '0;
		end
		case (cmd.op)
			lgtr_pkg::OP_CHECK: pick_q <= old_q;
			lgtr_pkg::OP_W_LD: begin
				a_q   <= (lgtr_pkg::OPND_W'(doc_rd) << 16) + lgtr_pkg::OPND_W'(alpha_q);
				b_q   <= (lgtr_pkg::OPND_W'(word_rd) << 16) + lgtr_pkg::OPND_W'(beta_q);
				den_q <= (lgtr_pkg::DEN_W'(tot_rd) << 16) + lgtr_pkg::DEN_W'(vb_q);
			end
			lgtr_pkg::OP_MUL0: pp_q <= 62'(a_q) * 62'(b_q[20:0]);
			lgtr_pkg::OP_MUL1: begin
				prod_q <= lgtr_pkg::PROD_W'(pp_q);
				pp_q   <= 62'(a_q) * 62'(b_q[40:21]);
			end
			lgtr_pkg::OP_MUL2: prod_q <= prod_q + (lgtr_pkg::PROD_W'(pp_q) << 21);
			lgtr_pkg::OP_W_ACC: begin
				total_q <= total_q + lgtr_pkg::TOT_W'(weight);
				if (k_q != kn_m1) k_q <= k_q + TW'(1);
			end
			lgtr_pkg::OP_TH0: begin
				tp_q  <= 64'(total_q[31:0]) * 64'(frac_q);
				k_q   <= '0;
				run_q <= '0;
			end
			lgtr_pkg::OP_TH1: begin
				thr_q <= lgtr_pkg::TOT_W'(tp_q >> 32);
				tp_q  <= 64'(total_q[63:32]) * 64'(frac_q);
			end
			lgtr_pkg::OP_TH2: begin
				thr_q <= thr_q + lgtr_pkg::TOT_W'(tp_q);
				tp_q  <= 64'(total_q[69:64]) * 64'(frac_q);
			end
			lgtr_pkg::OP_TH3: thr_q <= thr_q + (lgtr_pkg::TOT_W'(tp_q) << 32);
			lgtr_pkg::OP_P_CHK: begin
				run_q <= run_next;
				if (run_next > thr_q || k_q == kn_m1) pick_q <= k_q;
				else k_q <= k_q + TW'(1);
			end
			lgtr_pkg::OP_OUT: new_topic_q <= pick_q;
			default: ;
		endcase
	end

	assign status.clear_last = clr_cnt_q == CLW'(CLR_DEPTH - 1);
	assign status.range_ok   = (32'(doc_q) < MAX_DOCS) && (32'(word_q) < MAX_WORDS)
		&& ({1'b0, old_q} < kn_q);
	assign status.func_add   = !func_q;
	assign status.k_last     = k_q == kn_m1;
	assign status.hit        = run_next > thr_q;
	assign status.den_zero   = den_zero;
	assign status.div_done   = div_done;
	assign status.out_free   = out_free;

	assign out_valid = out_valid_q;
	assign new_topic = new_topic_q;

`ifndef ASSERT_OFF
	a_k_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lgtr_pkg::OP_P_CHK || cmd.op == lgtr_pkg::OP_W_ACC) |-> (k_q <= kn_m1))
		else $error("topic index beyond topics in use");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lgtr_pkg::OP_OUT) |-> out_free)
		else $error("result register overwritten");
	a_weight_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lgtr_pkg::OP_W_ACC && !den_zero) |-> ($past(div_done) && !div_busy))
		else $error("weight taken before division finished");
`endif

endmodule

[hw/rtl/lda_gibbs_topic_resampler.sv]
// Collapsed Gibbs topic resampler.
// Input channel (in_valid/in_ready) carries one token item: func, doc_index,
// word_id, old_topic, random_fraction. Output channel (out_valid/out_ready)
// returns one new_topic per item, in order. Config writes (cfg_we, cfg_index,
// cfg_data) set topic_count, vocab_size, alpha_prior, beta_prior; write only
// while the block is idle.
// An add item reads and updates its counts before its result goes out; an
// out-of-range item goes straight to its result. After each result the
// block returns to idle, where the next item is taken. A resample item takes
// the old token out of the counts, computes a weight for each topic in use,
// then walks the weights up to the pick: each weight runs one pass of the
// 98-step bit-serial divider (skipped when the denominator is zero), and the
// pick walk reads the stored weights one by one. Count tables sit in RAMs
// with registered reads. Reset: the count tables are cleared by a sweep
// over max(MAX_WORDS,MAX_DOCS)*64 addresses (262144 at the defaults); no
// item is accepted until it ends, config writes are taken throughout.
// Stall: the result waits in an output register; the next item is accepted
// meanwhile and its result is held back until the register is free.
module lda_gibbs_topic_resampler #(
	parameter int MAX_TOPICS = 64,
	parameter int MAX_WORDS  = 4096,
	parameter int MAX_DOCS   = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [9:0]  doc_index,
	input  logic [11:0] word_id,
	input  logic [5:0]  old_topic,
	input  logic [31:0] random_fraction,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  new_topic
);

	lgtr_pkg::cmd_t    cmd;
	lgtr_pkg::status_t status;

	lgtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	lgtr_dp #(
		.MAX_TOPICS (MAX_TOPICS),
		.MAX_WORDS  (MAX_WORDS),
		.MAX_DOCS   (MAX_DOCS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.func            (func),
		.doc_index       (doc_index),
		.word_id         (word_id),
		.old_topic       (old_topic),
		.random_fraction (random_fraction),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.new_topic       (new_topic),
		.cmd             (cmd),
		.status          (status)
	);

endmodule

[verif/lda_gibbs_topic_resampler_tb.sv]
module lda_gibbs_topic_resampler_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = lgtr_pkg::CFG_TOPIC_COUNT;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [9:0]  doc_index = '0;
	logic [11:0] word_id = '0;
	logic [5:0]  old_topic = '0;
	logic [31:0] random_fraction = '0;
	logic        out_valid;
	logic        out_ready = 1'b1;
	logic [5:0]  new_topic;

	localparam bit FN_ADD = 1'b0;
	localparam bit FN_RESAMPLE = 1'b1;
	localparam int IDLE_NONE = 0;
	localparam int IDLE_SEND = 1;
	localparam int IDLE_RECV = 2;
	localparam int IDLE_BOTH = 3;

	lda_gibbs_topic_resampler dut (.*);

	always #4 clk = ~clk;

	// predictor state
	bit [23:0] topic_tot[64];
	bit [23:0] word_cnt[int];
	bit [23:0] doc_cnt[int];
	bit [6:0]  topic_count_r = lgtr_pkg::RST_TOPIC_COUNT;
	bit [12:0] vocab_r = lgtr_pkg::RST_VOCAB_SIZE;
	bit [23:0] alpha_r = lgtr_pkg::RST_ALPHA;
	bit [23:0] beta_r = lgtr_pkg::RST_BETA;

	bit [5:0] topic_q[$];
	int errors = 0;
	int n_items = 0;
	int n_resample = 0;
	int n_results = 0;
	int idle_mode = IDLE_NONE;

	// token pool for well-formed resample sequences
	int tok_doc[$];
	int tok_word[$];
	int tok_topic[$];
	int doc_pool[8];
	int word_pool[8];

	function automatic int topics_used();
		int k;
		k = (topic_count_r == 0) ? 1 : int'(topic_count_r);
		if (k > 64) k = 64;
		return k;
	endfunction

	function automatic bit [23:0] word_get(int idx);
		return word_cnt.exists(idx) ? word_cnt[idx] : 24'd0;
	endfunction

	function automatic bit [23:0] doc_get(int idx);
		return doc_cnt.exists(idx) ? doc_cnt[idx] : 24'd0;
	endfunction

	function automatic void count_token(int d, int w, int k, bit up);
		bit [23:0] t, wc, dc;
		t = topic_tot[k];
		wc = word_get(w * 64 + k);
		dc = doc_get(d * 64 + k);
		if (up) begin
			if (t != '1) t++;
			if (wc != '1) wc++;
			if (dc != '1) dc++;
		end else begin
			if (t != 0) t--;
			if (wc != 0) wc--;
			if (dc != 0) dc--;
		end
		topic_tot[k] = t;
		word_cnt[w * 64 + k] = wc;
		doc_cnt[d * 64 + k] = dc;
	endfunction

	function automatic bit [63:0] topic_weight(int d, int w, int k);
		bit [40:0]  a, b, den;
		bit [81:0]  prod;
		bit [127:0] quo;
		a = (41'(doc_get(d * 64 + k)) << 16) + 41'(alpha_r);
		b = (41'(word_get(w * 64 + k)) << 16) + 41'(beta_r);
		den = (41'(topic_tot[k]) << 16) + 41'(vocab_r) * 41'(beta_r);
		prod = 82'(a) * 82'(b);
		if (den == 0) return (prod == 0) ? 64'd0 : '1;
		quo = (128'(prod) << 16) / 128'(den);
		return (quo[127:64] != 0) ? '1 : quo[63:0];
	endfunction

	function automatic bit [5:0] resample_topic(bit fn, int d, int w, int old,
			bit [31:0] frac);
		int kn, pick;
		bit [63:0]  wgt[64];
		bit [127:0] total, thr, run;
		kn = topics_used();
		if (old >= kn) return 6'(old);
		if (fn == FN_ADD) begin
			count_token(d, w, old, 1'b1);
			return 6'(old);
		end
		count_token(d, w, old, 1'b0);
		total = 0;
		for (int k = 0; k < kn; k++) begin
			wgt[k] = topic_weight(d, w, k);
			total += 128'(wgt[k]);
		end
		thr = (total * 128'(frac)) >> 32;
		pick = kn - 1;
		run = 0;
		for (int k = 0; k < kn; k++) begin
			run += 128'(wgt[k]);
			if (run > thr) begin
				pick = k;
				break;
			end
		end
		count_token(d, w, pick, 1'b1);
		return 6'(pick);
	endfunction

	always @(posedge clk) begin
		case (idle_mode)
			IDLE_RECV: out_ready <= $urandom_range(99) >= 58;
			IDLE_BOTH: out_ready <= $urandom_range(99) >= 27;
			default: out_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		bit [5:0] exp_topic;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (topic_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual new_topic %0d",
					$time, new_topic);
			end else begin
				exp_topic = topic_q.pop_front();
				if (new_topic !== exp_topic) begin
					errors++;
					$display("%0t: new_topic mismatch, expected %0d, actual %0d",
						$time, exp_topic, new_topic);
				end
			end
		end
	end

	task automatic send_item(bit fn, int d, int w, int old, bit [31:0] frac,
			output bit [5:0] res);
		int gap_pct;
		gap_pct = (idle_mode == IDLE_SEND) ? 58 : (idle_mode == IDLE_BOTH) ? 27 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		func <= fn;
		doc_index <= 10'(d);
		word_id <= 12'(w);
		old_topic <= 6'(old);
		random_fraction <= frac;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		res = resample_topic(fn, d, w, old, frac);
		topic_q = {topic_q, res};
		n_items++;
		if (fn == FN_RESAMPLE && old < topics_used()) n_resample++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (topic_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 24'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lgtr_pkg::CFG_TOPIC_COUNT: topic_count_r = 7'(val);
			lgtr_pkg::CFG_VOCAB_SIZE: vocab_r = 13'(val);
			lgtr_pkg::CFG_ALPHA: alpha_r = 24'(val);
			default: beta_r = 24'(val);
		endcase
	endtask

	task automatic set_config(int tc, int vs, int al, int be);
		write_reg(lgtr_pkg::CFG_TOPIC_COUNT, tc);
		write_reg(lgtr_pkg::CFG_VOCAB_SIZE, vs);
		write_reg(lgtr_pkg::CFG_ALPHA, al);
		write_reg(lgtr_pkg::CFG_BETA, be);
		tok_doc.delete();
		tok_word.delete();
		tok_topic.delete();
		for (int i = 0; i < 8; i++) begin
			doc_pool[i] = $urandom_range(1023);
			word_pool[i] = $urandom_range(4095);
		end
		doc_pool[0] = 1023;
		word_pool[0] = 4095;
		doc_pool[1] = 0;
		word_pool[1] = 0;
	endtask

	task automatic test_directed();
		bit [5:0] r;
		// default config, 64 topics
		send_item(FN_ADD, 1023, 4095, 63, 32'hFFFF_FFFF, r);
		send_item(FN_ADD, 0, 0, 0, 32'h0, r);
		send_item(FN_ADD, 1023, 4095, 32, 32'h0, r);
		send_item(FN_RESAMPLE, 1023, 4095, 63, 32'h8000_0000, r);
		set_config(4, 4096, 6554, 655);
		send_item(FN_RESAMPLE, 5, 7, 2, 32'h1234_5678, r);
		send_item(FN_RESAMPLE, 5, 7, 63, 32'h0, r);
		send_item(FN_ADD, 5, 7, 63, 32'h0, r);
		send_item(FN_ADD, 682, 2730, 3, 32'hAAAA_AAAA, r);
		send_item(FN_ADD, 341, 1365, 1, 32'h5555_5555, r);
		send_item(FN_RESAMPLE, 682, 2730, 3, 32'h0, r);
		send_item(FN_RESAMPLE, 341, 1365, 1, 32'hFFFF_FFFF, r);
		send_item(FN_RESAMPLE, 0, 0, 0, 32'h0000_0001, r);
		// topic_count 0 behaves as a single topic
		set_config(0, 4096, 6554, 655);
		send_item(FN_RESAMPLE, 9, 9, 0, 32'hFFFF_FFFF, r);
		send_item(FN_ADD, 9, 9, 1, 32'h0, r);
		// zero denominators: vocab and beta both zero
		set_config(3, 0, 6554, 0);
		send_item(FN_ADD, 20, 20, 1, 32'h0, r);
		send_item(FN_RESAMPLE, 20, 20, 1, 32'h4000_0000, r);
		send_item(FN_RESAMPLE, 21, 22, 0, 32'hC000_0000, r);
		// zero total weight picks the last topic
		set_config(5, 8191, 0, 0);
		send_item(FN_RESAMPLE, 30, 31, 2, 32'h9999_9999, r);
		send_item(FN_RESAMPLE, 30, 31, 4, 32'h0, r);
		// weight saturation
		set_config(6, 1, 24'hFF_FFFF, 1);
		send_item(FN_RESAMPLE, 40, 41, 0, 32'h7FFF_FFFF, r);
		send_item(FN_RESAMPLE, 40, 41, 5, 32'hFFFF_FFFF, r);
	endtask

	task automatic test_random(int tc, int vs, int al, int be, int mode, int count);
		bit [5:0] r;
		int sel, j, kn;
		set_config(tc, vs, al, be);
		idle_mode = mode;
		kn = topics_used();
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 30 || tok_doc.size() == 0) begin
				send_item(FN_ADD, doc_pool[$urandom_range(7)], word_pool[$urandom_range(7)],
					$urandom_range(kn - 1), $urandom, r);
				if (tok_doc.size() < 48) begin
					tok_doc = {tok_doc, int'(doc_index)};
					tok_word = {tok_word, int'(word_id)};
					tok_topic = {tok_topic, int'(r)};
				end
			end else if (sel < 85) begin
				j = $urandom_range(tok_doc.size() - 1);
				send_item(FN_RESAMPLE, tok_doc[j], tok_word[j], tok_topic[j], $urandom, r);
				tok_topic[j] = r;
			end else begin
				send_item(1'($urandom), $urandom_range(1023), $urandom_range(4095),
					$urandom_range(63), $urandom, r);
			end
		end
		drain();
		idle_mode = IDLE_NONE;
	endtask

	task automatic test_wide_topics();
		bit [5:0] r;
		set_config(127, 4096, 65536, 655);
		send_item(FN_ADD, 100, 200, 63, 32'h0, r);
		send_item(FN_ADD, 100, 200, 40, 32'h0, r);
		send_item(FN_RESAMPLE, 100, 200, 63, $urandom, r);
		send_item(FN_RESAMPLE, 100, 201, 33, $urandom, r);
		send_item(FN_ADD, 1023, 4095, 48, 32'h0, r);
		set_config(64, 4096, 6554, 655);
		send_item(FN_RESAMPLE, 1023, 4095, 48, $urandom, r);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(4, 4096, 6554, 655, IDLE_NONE, 400);
		test_random(3, 1000, 65536, 6554, IDLE_SEND, 400);
		test_random(5, 50, 1000, 300000, IDLE_RECV, 400);
		test_random(2, 8191, 24'hFF_FFFF, 24'hFF_FFFF, IDLE_BOTH, 400);
		test_random(8, 1, 0, 1, IDLE_NONE, 300);
		test_wide_topics();
		$display("covered %0d items (%0d resamples), %0d results checked, %0d errors",
			n_items, n_resample, n_results, errors);
		if (errors == 0 && topic_q.size() == 0)
			$display("lda_gibbs_topic_resampler_tb: clean");
		else
			$display("lda_gibbs_topic_resampler_tb: errors");
		$finish;
	end

	initial begin
		#60000000;
		$display("timeout with %0d results still expected", topic_q.size());
		$display("lda_gibbs_topic_resampler_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/lgtr_pkg.sv
hw/rtl/lgtr_ram.sv
hw/rtl/lgtr_div.sv
hw/rtl/lgtr_ctrl.sv
hw/rtl/lgtr_dp.sv
hw/rtl/lda_gibbs_topic_resampler.sv
verif/lda_gibbs_topic_resampler_tb.sv
